FILE: rtl/gregorian_to_long_count_assert.svh
// Assertion macros for the Gregorian to Long Count converter.
// Used by the port checker; expects clk_i and rst_ni in the including scope.
`ifndef GREGORIAN_TO_LONG_COUNT_ASSERT_SVH
`define GREGORIAN_TO_LONG_COUNT_ASSERT_SVH

// Same-cycle implication.
`define G2LC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define G2LC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/g2lc_pkg.sv
// Types, constants and calendar tables for the Gregorian to Long Count converter.
// No dependencies.
package g2lc_pkg;

  typedef struct packed {
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [13:0] year_number;
  } g2lc_in_t;

  typedef struct packed {
    logic [5:0] baktun_count;
    logic [4:0] katun_digit;
    logic [4:0] tun_digit;
    logic [4:0] uinal_digit;
    logic [4:0] kin_digit;
    logic       date_invalid;
  } g2lc_out_t;

  localparam int unsigned TotalW = 23;

  // Day number of 0001-01-01 in the Long Count.
  localparam logic [TotalW-1:0] LcOffset = 23'd1137143;

  // Reciprocals: floor(x / D) = (x * R) >> S, exact for the operand ranges used.
  localparam logic [13:0]       Recip100    = 14'd10486;   // S = 20, x < 2^14
  localparam logic [TotalW-1:0] Recip20     = 23'd6710887; // S = 27
  localparam logic [TotalW-1:0] Recip360    = 23'd5965233; // S = 31
  localparam logic [TotalW-1:0] Recip7200   = 23'd4772186; // S = 35
  localparam logic [TotalW-1:0] Recip144000 = 23'd7635498; // S = 40

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonMar = 4'd3;
  localparam logic [3:0] MonApr = 4'd4;
  localparam logic [3:0] MonMay = 4'd5;
  localparam logic [3:0] MonJun = 4'd6;
  localparam logic [3:0] MonJul = 4'd7;
  localparam logic [3:0] MonAug = 4'd8;
  localparam logic [3:0] MonSep = 4'd9;
  localparam logic [3:0] MonOct = 4'd10;
  localparam logic [3:0] MonNov = 4'd11;
  localparam logic [3:0] MonDec = 4'd12;

  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] days;
    unique case (mon)
      MonJan:  days = 9'd0;
      MonFeb:  days = 9'd31;
      MonMar:  days = 9'd59;
      MonApr:  days = 9'd90;
      MonMay:  days = 9'd120;
      MonJun:  days = 9'd151;
      MonJul:  days = 9'd181;
      MonAug:  days = 9'd212;
      MonSep:  days = 9'd243;
      MonOct:  days = 9'd273;
      MonNov:  days = 9'd304;
      MonDec:  days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon) inside
      MonFeb:                         len = leap ? 5'd29 : 5'd28;
      MonApr, MonJun, MonSep, MonNov: len = 5'd30;
      default:                        len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/gregorian_to_long_count.sv
// Gregorian date to Maya Long Count converter, top level.
// Depends on g2lc_pkg.
//
// Accepts one request per cycle while the result side does not stall, and presents its
// Long Count on the result port through six register stages: input, year minus one split
// by 100, leap rule and days before the year, day-count sum, four parallel reciprocal
// multiplies, and digit extraction into the result register. Each stage holds its request
// while the stage after it cannot take it, so a stalled result does not stop requests
// from filling empty stages behind it. Invalid dates give date_invalid = 1 and all digits
// zero.
module gregorian_to_long_count (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  g2lc_pkg::g2lc_in_t   req_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output g2lc_pkg::g2lc_out_t  res_o
);
  import g2lc_pkg::*;

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_q, vld_in, rdy;

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || res_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld_q[NumStages-2:0], req_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: input register
  g2lc_in_t in_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && vld_in[0]) begin
      in_q <= req_i;
    end
  end

  // Stage 1: year - 1 and its split by 100
  logic [13:0] py_a;
  logic [27:0] prod100;
  logic        bad_a;
  logic [13:0] s1_py_q;
  logic [7:0]  s1_q100_q;
  logic [4:0]  s1_day_q;
  logic [3:0]  s1_mon_q;
  logic        s1_bad_q;

  always_comb begin
    py_a    = in_q.year_number - 14'd1;
    prod100 = 28'(py_a) * 28'(Recip100);
    bad_a   = (in_q.year_number == 14'd0) || (in_q.month_number < MonJan)
           || (in_q.month_number > MonDec) || (in_q.day_of_month == 5'd0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && vld_in[1]) begin
      s1_py_q   <= py_a;
      s1_q100_q <= prod100[27:20];
      s1_day_q  <= in_q.day_of_month;
      s1_mon_q  <= in_q.month_number;
      s1_bad_q  <= bad_a;
    end
  end

  // Stage 2: leap rule, day check, days before the year
  logic [13:0]       rem100_b;
  logic [7:0]        cent_b;
  logic [1:0]        ylo_b;
  logic              leap_b;
  logic [TotalW-1:0] ydays_b;
  logic [TotalW-1:0] s2_ydays_q;
  logic [4:0]        s2_day_q;
  logic [3:0]        s2_mon_q;
  logic              s2_leap_q;
  logic              s2_bad_q;

  always_comb begin
    rem100_b = s1_py_q - 14'(14'(s1_q100_q) * 14'd100);
    cent_b   = s1_q100_q + 8'd1;
    ylo_b    = s1_py_q[1:0] + 2'd1;
    // century years follow the 400-year rule
    leap_b   = (rem100_b == 14'd99) ? (cent_b[1:0] == 2'd0) : (ylo_b == 2'd0);
    ydays_b  = TotalW'(s1_py_q) * TotalW'(365) + TotalW'(s1_py_q[13:2])
             - TotalW'(s1_q100_q) + TotalW'(s1_q100_q[7:2]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vld_in[2]) begin
      s2_ydays_q <= ydays_b;
      s2_day_q   <= s1_day_q;
      s2_mon_q   <= s1_mon_q;
      s2_leap_q  <= leap_b;
      s2_bad_q   <= s1_bad_q || (s1_day_q > month_length(s1_mon_q, leap_b));
    end
  end

  // Stage 3: Long Count day number
  logic [TotalW-1:0] total_c;
  logic [TotalW-1:0] s3_total_q;
  logic              s3_bad_q;

  always_comb begin
    total_c = s2_ydays_q + TotalW'(days_before_month(s2_mon_q))
            + TotalW'(s2_leap_q && (s2_mon_q > MonFeb))
            + TotalW'(s2_day_q) - TotalW'(1) + LcOffset;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vld_in[3]) begin
      s3_total_q <= total_c;
      s3_bad_q   <= s2_bad_q;
    end
  end

  // Stage 4: quotients by 20, 360, 7200 and 144000
  logic [2*TotalW-1:0] p20, p360, p7200, p144k;
  logic [TotalW-1:0]   s4_total_q;
  logic [18:0]         s4_q20_q;
  logic [14:0]         s4_q360_q;
  logic [10:0]         s4_q7200_q;
  logic [5:0]          s4_q144k_q;
  logic                s4_bad_q;

  always_comb begin
    p20   = (2*TotalW)'(s3_total_q) * (2*TotalW)'(Recip20);
    p360  = (2*TotalW)'(s3_total_q) * (2*TotalW)'(Recip360);
    p7200 = (2*TotalW)'(s3_total_q) * (2*TotalW)'(Recip7200);
    p144k = (2*TotalW)'(s3_total_q) * (2*TotalW)'(Recip144000);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4] && vld_in[4]) begin
      s4_total_q <= s3_total_q;
      s4_q20_q   <= p20[45:27];
      s4_q360_q  <= p360[45:31];
      s4_q7200_q <= p7200[45:35];
      s4_q144k_q <= p144k[45:40];
      s4_bad_q   <= s3_bad_q;
    end
  end

  // Stage 5: digits and result register
  logic [TotalW-1:0] kin_w;
  logic [18:0]       uinal_w;
  logic [14:0]       tun_w;
  logic [10:0]       katun_w;
  g2lc_out_t         res_d, res_q;

  always_comb begin
    kin_w   = s4_total_q - TotalW'(TotalW'(s4_q20_q) * TotalW'(20));
    uinal_w = s4_q20_q - 19'(19'(s4_q360_q) * 19'd18);
    tun_w   = s4_q360_q - 15'(15'(s4_q7200_q) * 15'd20);
    katun_w = s4_q7200_q - 11'(11'(s4_q144k_q) * 11'd20);
    res_d   = '0;
    if (s4_bad_q) begin
      res_d.date_invalid = 1'b1;
    end else begin
      res_d.baktun_count = s4_q144k_q;
      res_d.katun_digit  = katun_w[4:0];
      res_d.tun_digit    = tun_w[4:0];
      res_d.uinal_digit  = uinal_w[4:0];
      res_d.kin_digit    = kin_w[4:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5] && vld_in[5]) begin
      res_q <= res_d;
    end
  end

  assign req_ready_o = rdy[0];
  assign res_valid_o = vld_q[NumStages-1];
  assign res_o       = res_q;

endmodule

FILE: rtl/g2lc_chk.sv
// Port checker for the Gregorian to Long Count converter, bound to the top level.
// Depends on g2lc_pkg and gregorian_to_long_count_assert.svh.
`include "gregorian_to_long_count_assert.svh"

module g2lc_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_ready_o,
  input logic                res_valid_o,
  input logic                res_ready_i,
  input g2lc_pkg::g2lc_out_t res_o
);
  import g2lc_pkg::*;

  logic invalid_shown;
  logic digits_zero;
  logic digits_in_range;
  logic res_stalled;

  assign invalid_shown   = res_valid_o && res_o.date_invalid;
  assign digits_zero     = (res_o.baktun_count == 6'd0) && (res_o.katun_digit == 5'd0)
                        && (res_o.tun_digit == 5'd0) && (res_o.uinal_digit == 5'd0)
                        && (res_o.kin_digit == 5'd0);
  assign digits_in_range = (res_o.katun_digit < 5'd20) && (res_o.tun_digit < 5'd20)
                        && (res_o.uinal_digit < 5'd18) && (res_o.kin_digit < 5'd20);
  assign res_stalled     = res_valid_o && !res_ready_i;

  // invalid dates carry all-zero digits
  `G2LC_ASSERT_IMP(a_invalid_zero, invalid_shown, digits_zero, "invalid date with digits")

  // digits stay within their radices
  `G2LC_ASSERT_IMP(a_digit_range, res_valid_o, digits_in_range, "digit out of range")

  // a drained output leaves the whole pipe able to take a request
  `G2LC_ASSERT_IMP(a_ready_through, res_ready_i, req_ready_o, "request side stalled")

  // a stalled result holds
  `G2LC_ASSERT_NXT(a_res_hold, res_stalled, res_valid_o && $stable(res_o), "result changed")

endmodule

bind gregorian_to_long_count g2lc_chk u_g2lc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_o (req_ready_o),
  .res_valid_o (res_valid_o),
  .res_ready_i (res_ready_i),
  .res_o       (res_o)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for gregorian_to_long_count: directed and random dates checked against
// a day-count predictor of the Long Count. Depends on g2lc_pkg and the top level RTL.
module testbench;
  import g2lc_pkg::*;

  localparam int unsigned LcDayOfYearOne = 1137143;
  localparam int unsigned KinRadix       = 20;
  localparam int unsigned UinalRadix     = 18;
  localparam int unsigned TunRadix       = 20;
  localparam int unsigned KatunRadix     = 20;
  localparam int unsigned IdlePercent    = 27;
  localparam int unsigned StallLimit     = 4000;

  logic      clk_i;
  logic      rst_ni;
  logic      req_valid_i;
  logic      req_ready_o;
  g2lc_in_t  req_i;
  logic      res_valid_o;
  logic      res_ready_i;
  g2lc_out_t res_o;

  g2lc_out_t   pending_long_counts[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          no_gaps        = 1'b0;

  gregorian_to_long_count uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic bit year_is_leap(int unsigned y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    case (m) inside
      MonFeb:                         return year_is_leap(y) ? 29 : 28;
      MonApr, MonJun, MonSep, MonNov: return 30;
      default:                        return 31;
    endcase
  endfunction

  function automatic int unsigned days_before(int unsigned m);
    case (m)
      MonFeb:  return 31;
      MonMar:  return 59;
      MonApr:  return 90;
      MonMay:  return 120;
      MonJun:  return 151;
      MonJul:  return 181;
      MonAug:  return 212;
      MonSep:  return 243;
      MonOct:  return 273;
      MonNov:  return 304;
      MonDec:  return 334;
      default: return 0;
    endcase
  endfunction

  function automatic g2lc_out_t long_count_of(g2lc_in_t date);
    g2lc_out_t   lc;
    int unsigned y, m, d, py, days;
    lc = '0;
    y  = 32'(date.year_number);
    m  = 32'(date.month_number);
    d  = 32'(date.day_of_month);
    if (y == 0 || m < MonJan || m > MonDec || d == 0 || d > month_days(m, y)) begin
      lc.date_invalid = 1'b1;
      return lc;
    end
    py   = y - 1;
    days = 365 * py + py / 4 - py / 100 + py / 400 + days_before(m)
         + ((m > MonFeb && year_is_leap(y)) ? 1 : 0) + (d - 1) + LcDayOfYearOne;
    lc.kin_digit    = 5'(days % KinRadix);   days = days / KinRadix;
    lc.uinal_digit  = 5'(days % UinalRadix); days = days / UinalRadix;
    lc.tun_digit    = 5'(days % TunRadix);   days = days / TunRadix;
    lc.katun_digit  = 5'(days % KatunRadix); days = days / KatunRadix;
    lc.baktun_count = 6'(days % 64);
    return lc;
  endfunction

  function automatic g2lc_in_t make_date(int unsigned d, int unsigned m, int unsigned y);
    g2lc_in_t date;
    date.day_of_month = 5'(d);
    date.month_number = 4'(m);
    date.year_number  = 14'(y);
    return date;
  endfunction

  function automatic g2lc_in_t random_date();
    int unsigned y, m, len;
    case ($urandom_range(9))
      0:       y = 100 * $urandom_range(1, 99);
      1:       y = $urandom_range(10000, 16383);
      default: y = $urandom_range(1, 9999);
    endcase
    m   = $urandom_range(MonJan, MonDec);
    len = month_days(m, y);
    if ($urandom_range(9) < 3) return make_date(len, m, y);
    return make_date($urandom_range(1, len), m, y);
  endfunction

  // noise: raw fields, or a well-formed date with its day or its month broken
  function automatic g2lc_in_t broken_date();
    g2lc_in_t    date;
    int unsigned m;
    date = random_date();
    case ($urandom_range(2))
      0: date = 23'($urandom);
      1: begin
        m = 32'(date.month_number);
        date.day_of_month = 5'($urandom_range(month_days(m, 32'(date.year_number)) + 1, 31));
        if (m == MonJan || m == MonMar || m == MonMay || m == MonJul || m == MonAug ||
            m == MonOct || m == MonDec) date.day_of_month = 5'd0;
      end
      default: date.month_number = 4'(($urandom_range(1) == 0) ? 0 : $urandom_range(13, 15));
    endcase
    return date;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic send_date(g2lc_in_t date);
    if (!no_gaps) begin
      while ($urandom_range(99) < IdlePercent) begin
        req_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_valid_i <= 1'b1;
    req_i       <= date;
    do @(posedge clk_i); while (!req_ready_o);
    pending_long_counts.push_back(long_count_of(date));
  endtask

  task automatic check_long_count(g2lc_out_t got);
    g2lc_out_t want;
    if (pending_long_counts.size() == 0) begin
      flag_mismatch($sformatf("result %p with no pending request", got));
      return;
    end
    want = pending_long_counts.pop_front();
    if (got.baktun_count != want.baktun_count)
      flag_mismatch($sformatf("baktun %0d, want %0d", got.baktun_count, want.baktun_count));
    if (got.katun_digit != want.katun_digit)
      flag_mismatch($sformatf("katun %0d, want %0d", got.katun_digit, want.katun_digit));
    if (got.tun_digit != want.tun_digit)
      flag_mismatch($sformatf("tun %0d, want %0d", got.tun_digit, want.tun_digit));
    if (got.uinal_digit != want.uinal_digit)
      flag_mismatch($sformatf("uinal %0d, want %0d", got.uinal_digit, want.uinal_digit));
    if (got.kin_digit != want.kin_digit)
      flag_mismatch($sformatf("kin %0d, want %0d", got.kin_digit, want.kin_digit));
    if (got.date_invalid != want.date_invalid)
      flag_mismatch($sformatf("invalid %0b, want %0b", got.date_invalid, want.date_invalid));
  endtask

  // result side: check, stall at random, watch for a hang
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready_i <= 1'b0;
    end else begin
      if (res_valid_o && res_ready_i) check_long_count(res_o);
      if ((req_valid_i && req_ready_o) || (res_valid_o && res_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("gregorian_to_long_count regression: fail");
        $finish;
      end else begin
        res_ready_i <= no_gaps || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  task automatic test_directed_dates();
    send_date(make_date(1, MonJan, 1));
    send_date(make_date(21, MonDec, 2012));
    send_date(make_date(20, MonDec, 2012));
    send_date(make_date(31, MonDec, 9999));
    send_date(make_date(31, MonDec, 16383));
    send_date(make_date(1, MonJan, 10000));
    send_date(make_date(1, MonJan, 0));
    send_date(make_date(15, 0, 2000));
    send_date(make_date(15, 13, 2000));
    send_date(make_date(31, 15, 16383));
    send_date(make_date(0, MonJun, 1999));
    send_date(make_date(31, MonJan, 1999));
    send_date(make_date(31, MonApr, 1999));
    send_date(make_date(30, MonNov, 1999));
    send_date(make_date(29, MonFeb, 2000));
    send_date(make_date(29, MonFeb, 1900));
    send_date(make_date(29, MonFeb, 2024));
    send_date(make_date(29, MonFeb, 2023));
    send_date(make_date(28, MonFeb, 2023));
    send_date(make_date(30, MonFeb, 2000));
    send_date(make_date(1, MonMar, 2000));
    send_date(make_date(1, MonMar, 1900));
    send_date(make_date(31, MonDec, 400));
    send_date(make_date(0, 0, 0));
  endtask

  task automatic test_random_dates(int unsigned count);
    repeat (count) begin
      if ($urandom_range(9) < 8) begin
        send_date(random_date());
      end else begin
        send_date(broken_date());
      end
    end
  endtask

  task automatic test_back_to_back(int unsigned count);
    no_gaps = 1'b1;
    test_random_dates(count);
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_dates();
    test_random_dates(600);
    test_back_to_back(300);
    test_random_dates(300);
    req_valid_i <= 1'b0;
    while (pending_long_counts.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("gregorian_to_long_count regression: pass");
    end else begin
      $display("gregorian_to_long_count regression: fail");
    end
    $finish;
  end

endmodule
